>>> rtl/lrdc_pkg.sv
`default_nettype none

package lrdc_pkg;

  // Fixed field widths of the item formats, source and block counts, and the queue depth.
  localparam int unsigned AddrW    = 6;
  localparam int unsigned RegW     = 5;
  localparam int unsigned BlockW   = 2;
  localparam int unsigned NumSrc   = 3;
  localparam int unsigned SrcSelW  = 2;
  localparam int unsigned BlkCount = 4;
  localparam int unsigned FifoDepth = 2;

  // Basic block tags.
  localparam logic [BlockW-1:0] BLK_SETUP = 2'd0;
  localparam logic [BlockW-1:0] BLK_BODY  = 2'd1;
  localparam logic [BlockW-1:0] BLK_AFTER = 2'd2;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_REPORT = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_LOCAL     = 3'd1,
    KIND_INTERLOOP = 3'd2,
    KIND_INVARIANT = 3'd3,
    KIND_POSTLOOP  = 3'd4,
    KIND_BAD       = 3'd5
  } kind_e;

  // Commands passed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_REPORT = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_LOAD = 3'd1,
    ST_REC  = 3'd2,
    ST_SRC  = 3'd3,
    ST_EMIT = 3'd4
  } state_e;

  typedef struct packed {
    mode_e             mode;
    logic [AddrW-1:0]  address;
    logic [BlockW-1:0] block;
    logic              dest_valid;
    logic [RegW-1:0]   dest_reg;
    logic              src_a_valid;
    logic [RegW-1:0]   src_a;
    logic              src_b_valid;
    logic [RegW-1:0]   src_b;
    logic              src_c_valid;
    logic [RegW-1:0]   src_c;
  } in_t;

  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] cons_addr;
    logic [RegW-1:0]  src_reg;
    logic             producer_valid;
    logic [AddrW-1:0] prod_addr;
    logic             previous_valid;
    logic [AddrW-1:0] previous_address;
    logic             last;
  } out_t;

  typedef struct packed {
    logic            valid;
    logic [RegW-1:0] num;
  } src_t;

  typedef struct packed {
    op_e                     op;
    logic [AddrW-1:0]        address;
    logic [BlockW-1:0]       block;
    logic                    dest_valid;
    logic [RegW-1:0]         dest_reg;
    src_t [NumSrc-1:0]       src;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/lrdc_front.sv
`default_nettype none

module lrdc_front #(
  parameter int unsigned PROGRAM_DEPTH = 64,
  parameter int unsigned NUM_REGS      = 32,
  parameter int unsigned MAX_SOURCES   = 3
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire lrdc_pkg::in_t in_data_i,
  input  wire logic          full_i,
  output logic               push_o,
  output lrdc_pkg::cmd_t     cmd_o
);
  import lrdc_pkg::*;

  localparam int unsigned CntW = $clog2(PROGRAM_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > AddrW) ? CntW : AddrW;
  localparam int unsigned TrkW = RegW + 2;

  logic [CntW-1:0]              count_q, count_d;
  logic                         accept;
  logic                         room;
  logic                         bad;
  logic                         dest_trk;
  logic [NumSrc-1:0]            raw_v;
  logic [NumSrc-1:0]            keep;
  logic [NumSrc-1:0][RegW-1:0]  raw_r;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign room       = count_q < CntW'(PROGRAM_DEPTH);
  assign bad        = CmpW'(in_data_i.address) >= CmpW'(count_q);
  assign dest_trk   = {2'b00, in_data_i.dest_reg} < TrkW'(NUM_REGS);
  assign raw_r      = {in_data_i.src_c, in_data_i.src_b, in_data_i.src_a};

  // Trackable sources, minus the ones past the source limit and repeats.
  always_comb begin
    raw_v[0] = in_data_i.src_a_valid;
    raw_v[1] = in_data_i.src_b_valid;
    raw_v[2] = in_data_i.src_c_valid;
    for (int s = 0; s < NumSrc; s++) begin
      raw_v[s] = raw_v[s] && ({2'b00, raw_r[s]} < TrkW'(NUM_REGS));
    end
    for (int s = 0; s < NumSrc; s++) begin
      keep[s] = raw_v[s] && (s < MAX_SOURCES);
      for (int t = 0; t < s; t++) begin
        if (raw_v[t] && (raw_r[t] == raw_r[s])) begin
          keep[s] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    push_o           = 1'b0;
    count_d          = count_q;
    cmd_o.op         = OP_LOAD;
    cmd_o.address    = in_data_i.address;
    cmd_o.block      = in_data_i.block;
    cmd_o.dest_valid = in_data_i.dest_valid && dest_trk;
    cmd_o.dest_reg   = in_data_i.dest_reg;
    for (int s = 0; s < NumSrc; s++) begin
      cmd_o.src[s].valid = keep[s];
      cmd_o.src[s].num   = raw_r[s];
    end
    case (in_data_i.mode)
      MODE_LOAD: begin
        push_o = accept && room;
        if (accept && room) begin
          count_d = count_q + CntW'(1);
        end
      end
      MODE_REPORT: begin
        push_o   = accept;
        cmd_o.op = bad ? OP_BAD : OP_REPORT;
      end
      MODE_CLEAR: begin
        push_o   = accept;
        cmd_o.op = OP_CLEAR;
        if (accept) begin
          count_d = '0;
        end
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lrdc_fifo.sv
`default_nettype none

module lrdc_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire lrdc_pkg::cmd_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output lrdc_pkg::cmd_t      data_o
);
  import lrdc_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);

  cmd_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = cnt_q == (PtrW + 1)'(FifoDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PtrW + 1)'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command popped from an empty queue");
`endif

endmodule

`default_nettype wire

>>> rtl/lrdc_back.sv
`default_nettype none

module lrdc_back #(
  parameter int unsigned PROGRAM_DEPTH = 64,
  parameter int unsigned NUM_REGS      = 32,
  parameter int unsigned MAX_SOURCES   = 3
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire lrdc_pkg::cmd_t cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output lrdc_pkg::out_t      out_data_o
);
  import lrdc_pkg::*;

  localparam int unsigned AW = $clog2(PROGRAM_DEPTH);
  localparam int unsigned RW = $clog2(NUM_REGS);
  localparam int unsigned NS = MAX_SOURCES;
  localparam int unsigned SW = (NS > 1) ? $clog2(NS) : 1;
  localparam int unsigned NW = $clog2(NS + 1);

  typedef struct packed {
    logic [BlockW-1:0]        block;
    logic [NS-1:0]            src_valid;
    logic [NS-1:0][RegW-1:0]  src_num;
    logic [NS-1:0]            loc_valid;
    logic [NS-1:0][AW-1:0]    loc_addr;
  } rec_t;

  state_e                state_q, state_d;
  logic [NW-1:0]         idx_q, idx_d;
  logic [NW-1:0]         n_q, n_d;
  logic [NW-1:0]         k_q, k_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  cmd_t                  cmd_q, cmd_d;
  logic                  clr;

  // Last writer per block and register: valid bits in flops, addresses in memory.
  // One memory word per register holds the addresses of all blocks.
  logic [NUM_REGS-1:0]           lw_valid_q [BlkCount];
  logic [BlkCount-1:0][AW-1:0]   lw_mem [NUM_REGS];
  logic [RW-1:0]                 lw_raddr;
  logic                          lw_we;
  logic [BlkCount-1:0][AW-1:0]   lwa_q;
  logic [BlkCount-1:0]           lwv_q;

  rec_t                  rec_mem [PROGRAM_DEPTH];
  rec_t                  rec_q;
  rec_t                  rec_wdata;
  logic                  rec_we;
  logic                  rec_re;

  logic [NS-1:0]         loc_v_q, loc_v_d;
  logic [NS-1:0][AW-1:0] loc_a_q, loc_a_d;

  out_t                  res_q [NS];
  out_t                  res_item;
  logic                  res_we;
  logic                  found;

  logic [SrcSelW-1:0]    src_sel;
  logic [SrcSelW-1:0]    prev_sel;
  logic [NW-1:0]         prev;

  out_t                  out_q;
  out_t                  out_item;
  logic                  out_valid_q;
  logic                  out_load;
  logic                  emit_last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign prev        = idx_q - NW'(1);
  assign src_sel     = SrcSelW'(idx_q);
  assign prev_sel    = SrcSelW'(prev);

  always_comb begin : next_state
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          case (cmd_i.op)
            OP_LOAD:   state_d = ST_LOAD;
            OP_REPORT: state_d = ST_REC;
            OP_BAD:    state_d = ST_EMIT;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        if (idx_q == NW'(NS)) begin
          state_d = ST_IDLE;
        end
      end
      ST_REC: begin
        state_d = ST_SRC;
      end
      ST_SRC: begin
        if (idx_q == NW'(NS)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Classification of one source from its record and the last writer lookup.
  always_comb begin : classify
    res_item           = '0;
    res_item.cons_addr = cmd_q.address;
    res_item.src_reg   = rec_q.src_num[SW'(prev)];
    found              = 1'b0;
    if (rec_q.src_valid[SW'(prev)]) begin
      if (rec_q.loc_valid[SW'(prev)]) begin
        found                   = 1'b1;
        res_item.kind           = KIND_LOCAL;
        res_item.producer_valid = 1'b1;
        res_item.prod_addr      = AddrW'(rec_q.loc_addr[SW'(prev)]);
      end else if (rec_q.block == BLK_BODY && lwv_q[BLK_BODY]) begin
        found                     = 1'b1;
        res_item.kind             = KIND_INTERLOOP;
        res_item.producer_valid   = lwv_q[BLK_SETUP];
        res_item.prod_addr        = lwv_q[BLK_SETUP] ? AddrW'(lwa_q[BLK_SETUP]) : '0;
        res_item.previous_valid   = 1'b1;
        res_item.previous_address = AddrW'(lwa_q[BLK_BODY]);
      end else if (rec_q.block == BLK_AFTER && lwv_q[BLK_BODY]) begin
        found                   = 1'b1;
        res_item.kind           = KIND_POSTLOOP;
        res_item.producer_valid = 1'b1;
        res_item.prod_addr      = AddrW'(lwa_q[BLK_BODY]);
      end else if ((rec_q.block == BLK_BODY || rec_q.block == BLK_AFTER) &&
                   lwv_q[BLK_SETUP]) begin
        found                   = 1'b1;
        res_item.kind           = KIND_INVARIANT;
        res_item.producer_valid = 1'b1;
        res_item.prod_addr      = AddrW'(lwa_q[BLK_SETUP]);
      end
    end
  end

  always_comb begin : control
    pop_o     = 1'b0;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    n_d       = n_q;
    k_d       = k_q;
    ptr_d     = ptr_q;
    clr       = 1'b0;
    lw_raddr  = '0;
    lw_we     = 1'b0;
    rec_we    = 1'b0;
    rec_re    = 1'b0;
    loc_v_d   = loc_v_q;
    loc_a_d   = loc_a_q;
    res_we    = 1'b0;
    out_load  = 1'b0;
    out_item  = out_q;
    emit_last = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          idx_d = '0;
          n_d   = '0;
          k_d   = '0;
          if (cmd_i.op == OP_CLEAR) begin
            clr   = 1'b1;
            ptr_d = '0;
          end
        end
      end
      ST_LOAD: begin
        // One source lookup per cycle; each answer is registered before it is used.
        if (idx_q < NW'(NS)) begin
          lw_raddr = RW'(cmd_q.src[src_sel].num);
        end
        if (idx_q != '0) begin
          loc_v_d[SW'(prev)] = cmd_q.src[prev_sel].valid && lwv_q[cmd_q.block];
          loc_a_d[SW'(prev)] = lwa_q[cmd_q.block];
        end
        idx_d = idx_q + NW'(1);
        if (idx_q == NW'(NS)) begin
          rec_we = 1'b1;
          lw_we  = cmd_q.dest_valid;
          ptr_d  = ptr_q + AW'(1);
        end
      end
      ST_REC: begin
        rec_re = 1'b1;
      end
      ST_SRC: begin
        if (idx_q < NW'(NS)) begin
          lw_raddr = RW'(rec_q.src_num[SW'(idx_q)]);
        end
        if (idx_q != '0 && found) begin
          res_we = 1'b1;
          n_d    = n_q + NW'(1);
        end
        idx_d = idx_q + NW'(1);
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          k_d      = k_q + NW'(1);
          if (n_q == '0) begin
            out_item           = '0;
            out_item.kind      = (cmd_q.op == OP_BAD) ? KIND_BAD : KIND_NONE;
            out_item.cons_addr = cmd_q.address;
            out_item.last      = 1'b1;
          end else begin
            out_item      = res_q[SW'(k_q)];
            out_item.last = (k_q == n_q - NW'(1));
          end
          emit_last = out_item.last;
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_comb begin : record_pack
    rec_wdata.block     = cmd_q.block;
    for (int s = 0; s < NS; s++) begin
      rec_wdata.src_valid[s] = cmd_q.src[s].valid;
      rec_wdata.src_num[s]   = cmd_q.src[s].num;
    end
    rec_wdata.loc_valid = loc_v_d;
    rec_wdata.loc_addr  = loc_a_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      n_q     <= '0;
      k_q     <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      k_q     <= k_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BlkCount; b++) begin
        lw_valid_q[b] <= '0;
      end
    end else if (clr) begin
      for (int b = 0; b < BlkCount; b++) begin
        lw_valid_q[b] <= '0;
      end
    end else if (lw_we) begin
      lw_valid_q[cmd_q.block][RW'(cmd_q.dest_reg)] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lw_we) begin
      lw_mem[RW'(cmd_q.dest_reg)][cmd_q.block] <= ptr_q;
    end
    lwa_q <= lw_mem[lw_raddr];
    for (int b = 0; b < BlkCount; b++) begin
      lwv_q[b] <= lw_valid_q[b][lw_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[ptr_q] <= rec_wdata;
    end
    if (rec_re) begin
      rec_q <= rec_mem[AW'(cmd_q.address)];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    loc_v_q <= loc_v_d;
    loc_a_q <= loc_a_d;
    if (res_we) begin
      res_q[SW'(n_q)] <= res_item;
    end
    if (out_load) begin
      out_q <= out_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_load_advances_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && idx_q == NW'(NS)) |=> (ptr_q == AW'($past(ptr_q) + AW'(1))))
    else $error("load pointer did not advance after a load");
  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(NS))
    else $error("more results collected than sources");
  a_bad_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_BAD) |-> (out_q.last && out_q.src_reg == '0))
    else $error("bad address result is not a lone final transfer");
`endif

endmodule

`default_nettype wire

>>> rtl/loop_register_dependency_classifier_unit.sv
`default_nettype none

// Loop register dependency classifier.
// Input channel (in_valid_i/in_ready_o/in_data_i): one transfer is a command.
// Mode load stores the next instruction at the next free address, mode clear
// empties the program, mode report asks for the dependencies of one address.
// Output channel (out_valid_o/out_ready_i/out_data_o): a report yields one to
// MAX_SOURCES result transfers in source order; the final one carries last.
// A front stage accepts commands into a two-entry queue, so the input keeps
// taking transfers while a result waits at the output register.
// In the back end a load makes one last-writer memory lookup per source and
// then writes its record. A report reads its record, looks up each source and
// then emits the results. Clear is done from idle; a bad address goes straight
// to its single result. A stalled receiver holds the output register; the back
// end waits, the queue fills and in_ready_o drops. Reset empties the program
// and the queue; the instruction memory needs no clearing pass.
module loop_register_dependency_classifier_unit #(
  parameter int unsigned PROGRAM_DEPTH = 64,
  parameter int unsigned NUM_REGS      = 32,
  parameter int unsigned MAX_SOURCES   = 3
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire lrdc_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output lrdc_pkg::out_t     out_data_o
);
  import lrdc_pkg::*;

  logic fifo_full;
  logic fifo_empty;
  logic push;
  logic pop;
  cmd_t cmd_push;
  cmd_t cmd_head;

  // Front end: accepts commands, counts loaded instructions, checks report
  // addresses and drops repeated or untrackable sources.
  lrdc_front #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .NUM_REGS      (NUM_REGS),
    .MAX_SOURCES   (MAX_SOURCES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (fifo_full),
    .push_o     (push),
    .cmd_o      (cmd_push)
  );

  // Short command queue that decouples the two halves.
  lrdc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_push),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .data_o  (cmd_head)
  );

  // Back end: owns the instruction memory and the last-writer tables and
  // produces the result transfers.
  lrdc_back #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .NUM_REGS      (NUM_REGS),
    .MAX_SOURCES   (MAX_SOURCES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (fifo_empty),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_loop_register_dependency_classifier_unit.sv
`timescale 1ns / 1ps

module tb_loop_register_dependency_classifier_unit;
  import lrdc_pkg::*;

  localparam int unsigned PROGRAM_DEPTH = 64;
  localparam int unsigned NUM_REGS      = 32;
  localparam int unsigned MAX_SOURCES   = 3;
  localparam int unsigned QUIET_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES  = 40;

  // Block tag outside the three real blocks, and the mode value with no meaning.
  localparam logic [BlockW-1:0] BLK_OTHER  = 2'd3;
  localparam mode_e             MODE_SPARE = mode_e'(2'd3);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  loop_register_dependency_classifier_unit #(
    .PROGRAM_DEPTH(PROGRAM_DEPTH),
    .NUM_REGS     (NUM_REGS),
    .MAX_SOURCES  (MAX_SOURCES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Commands waiting to be driven, and dependency results still owed by the block.
  in_t  pending_cmd_q[$];
  out_t expected_deps_q[$];

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit cmd_taken = 1'b0;
  bit res_taken = 1'b0;
  int send_gap = 0;
  int send_burst = 0;
  int recv_wait = 0;
  int recv_burst = 0;

  // Shadow copy of the program as the block should hold it.
  int unsigned       prog_len = 0;
  logic              writer_v [3][NUM_REGS];
  logic [AddrW-1:0]  writer_a [3][NUM_REGS];
  logic [BlockW-1:0] rec_block [PROGRAM_DEPTH];
  logic              rec_dest_v [PROGRAM_DEPTH];
  logic [RegW-1:0]   rec_dest [PROGRAM_DEPTH];
  src_t              rec_src [PROGRAM_DEPTH][NumSrc];

  function automatic out_t dep_result(kind_e k, logic [AddrW-1:0] cons, logic [RegW-1:0] r,
                                      logic pv, logic [AddrW-1:0] pa,
                                      logic qv, logic [AddrW-1:0] qa);
    out_t o;
    o.kind             = k;
    o.cons_addr        = cons;
    o.src_reg          = r;
    o.producer_valid   = pv;
    o.prod_addr        = pv ? pa : '0;
    o.previous_valid   = qv;
    o.previous_address = qv ? qa : '0;
    o.last             = 1'b0;
    return o;
  endfunction

  // Appends one command to the list that the sender drives.
  task automatic queue_cmd(input in_t c);
    pending_cmd_q.insert(pending_cmd_q.size(), c);
  endtask

  // Updates the shadow program for one accepted command and queues the results
  // a report must produce, in source order.
  task automatic classify_cmd(input in_t cmd);
    out_t              found_q[$];
    logic [BlockW-1:0] blk;
    logic [RegW-1:0]   r;
    logic [AddrW-1:0]  cons;
    logic              dup;
    logic              hit;
    case (cmd.mode)
      MODE_CLEAR: begin
        prog_len = 0;
        foreach (writer_v[b, i]) begin
          writer_v[b][i] = 1'b0;
          writer_a[b][i] = '0;
        end
      end
      MODE_LOAD: begin
        if (prog_len < PROGRAM_DEPTH) begin
          rec_block[prog_len]  = cmd.block;
          rec_dest_v[prog_len] = cmd.dest_valid;
          rec_dest[prog_len]   = cmd.dest_reg;
          rec_src[prog_len][0] = '{cmd.src_a_valid, cmd.src_a};
          rec_src[prog_len][1] = '{cmd.src_b_valid, cmd.src_b};
          rec_src[prog_len][2] = '{cmd.src_c_valid, cmd.src_c};
          // Block tag 3 instructions never become setup or loop body writers.
          if (cmd.dest_valid && cmd.block != BLK_OTHER) begin
            writer_v[cmd.block][cmd.dest_reg] = 1'b1;
            writer_a[cmd.block][cmd.dest_reg] = AddrW'(prog_len);
          end
          prog_len++;
        end
      end
      MODE_REPORT: begin
        cons = cmd.address;
        if (32'(cons) >= prog_len) begin
          found_q.insert(found_q.size(),
                         dep_result(KIND_BAD, cons, '0, 1'b0, '0, 1'b0, '0));
        end else begin
          blk = rec_block[cons];
          for (int s = 0; s < int'(NumSrc); s++) begin
            if (!rec_src[cons][s].valid) continue;
            r = rec_src[cons][s].num;
            dup = 1'b0;
            for (int t = 0; t < s; t++) begin
              if (rec_src[cons][t].valid && rec_src[cons][t].num == r) dup = 1'b1;
            end
            if (dup) continue;
            // Nearest earlier writer inside the same block wins.
            hit = 1'b0;
            for (int i = int'(cons) - 1; i >= 0 && !hit; i--) begin
              if (rec_block[i] == blk && rec_dest_v[i] && rec_dest[i] == r) begin
                found_q.insert(found_q.size(),
                               dep_result(KIND_LOCAL, cons, r, 1'b1, AddrW'(i),
                                          1'b0, '0));
                hit = 1'b1;
              end
            end
            if (hit) continue;
            // Otherwise the whole loaded program's last writers per block decide.
            if (blk == BLK_BODY) begin
              if (writer_v[BLK_BODY][r]) begin
                found_q.insert(found_q.size(),
                               dep_result(KIND_INTERLOOP, cons, r,
                                          writer_v[BLK_SETUP][r], writer_a[BLK_SETUP][r],
                                          1'b1, writer_a[BLK_BODY][r]));
              end else if (writer_v[BLK_SETUP][r]) begin
                found_q.insert(found_q.size(),
                               dep_result(KIND_INVARIANT, cons, r, 1'b1,
                                          writer_a[BLK_SETUP][r], 1'b0, '0));
              end
            end else if (blk == BLK_AFTER) begin
              if (writer_v[BLK_BODY][r]) begin
                found_q.insert(found_q.size(),
                               dep_result(KIND_POSTLOOP, cons, r, 1'b1,
                                          writer_a[BLK_BODY][r], 1'b0, '0));
              end else if (writer_v[BLK_SETUP][r]) begin
                found_q.insert(found_q.size(),
                               dep_result(KIND_INVARIANT, cons, r, 1'b1,
                                          writer_a[BLK_SETUP][r], 1'b0, '0));
              end
            end
          end
          if (found_q.size() == 0) begin
            found_q.insert(found_q.size(),
                           dep_result(KIND_NONE, cons, '0, 1'b0, '0, 1'b0, '0));
          end
        end
        found_q[found_q.size() - 1].last = 1'b1;
        foreach (found_q[k]) expected_deps_q.insert(expected_deps_q.size(), found_q[k]);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Idle length for one transfer; now and then a run of back-to-back transfers.
  function automatic int draw_idle(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 30);
    return $urandom_range(0, 9);
  endfunction

  function automatic in_t load_cmd(logic [BlockW-1:0] blk, logic dv, logic [RegW-1:0] d,
                                   logic av, logic [RegW-1:0] a, logic bv,
                                   logic [RegW-1:0] b, logic cv, logic [RegW-1:0] c);
    in_t x;
    x.mode        = MODE_LOAD;
    x.address     = AddrW'($urandom_range(0, 63));
    x.block       = blk;
    x.dest_valid  = dv;
    x.dest_reg    = d;
    x.src_a_valid = av;
    x.src_a       = a;
    x.src_b_valid = bv;
    x.src_b       = b;
    x.src_c_valid = cv;
    x.src_c       = c;
    return x;
  endfunction

  // Report, clear and spare commands carry random noise in the unused fields.
  function automatic in_t other_cmd(mode_e m, logic [AddrW-1:0] addr);
    logic [63:0] noise;
    in_t x;
    noise     = {$urandom(), $urandom()};
    x         = noise[$bits(in_t)-1:0];
    x.mode    = m;
    x.address = addr;
    return x;
  endfunction

  // Registers mostly from a small pool so that writers and readers meet.
  function automatic logic [RegW-1:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return RegW'($urandom_range(0, 31));
    return RegW'($urandom_range(0, 5));
  endfunction

  function automatic in_t rand_instr(logic [BlockW-1:0] blk);
    return load_cmd(blk, $urandom_range(0, 3) != 0, pick_reg(),
                    $urandom_range(0, 3) != 0, pick_reg(),
                    $urandom_range(0, 2) != 0, pick_reg(),
                    $urandom_range(0, 1) != 0, pick_reg());
  endfunction

  // Sender: presents the next command after its idle gap and holds it until
  // the transfer happens.
  always @(negedge clk_i) begin
    logic nxt_valid;
    nxt_valid = in_valid_i;
    if (cmd_taken) begin
      cmd_taken = 1'b0;
      nxt_valid = 1'b0;
    end
    if (rst_ni && !nxt_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_cmd_q.size() != 0) begin
        in_data_i <= pending_cmd_q.pop_front();
        nxt_valid = 1'b1;
        send_gap  = draw_idle(send_burst);
      end
    end
    in_valid_i <= nxt_valid;
  end

  // Receiver: stalls a drawn number of cycles on each result before taking it.
  always @(negedge clk_i) begin
    if (res_taken) begin
      res_taken = 1'b0;
      recv_wait = draw_idle(recv_burst);
    end
    if (out_valid_o && recv_wait > 0) recv_wait--;
    out_ready_i <= rst_ni && recv_wait == 0;
  end

  // Monitor: predicts on every command transfer, checks every result transfer,
  // and ends the run if nothing moves for too long.
  always @(posedge clk_i) begin
    out_t want;
    logic in_fire;
    logic out_fire;
    if (rst_ni) begin
      in_fire  = in_valid_i && in_ready_o;
      out_fire = out_valid_o && out_ready_i;
      if (in_fire) begin
        classify_cmd(in_data_i);
        cmd_taken = 1'b1;
      end
      if (out_fire) begin
        res_taken = 1'b1;
        if (expected_deps_q.size() == 0) begin
          $error("unexpected result transfer: kind %0d consumer %0d",
                 out_data_o.kind, out_data_o.cons_addr);
          mismatches++;
        end else begin
          want = expected_deps_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_data_o.kind));
          check_field("cons_addr", 32'(want.cons_addr),
                      32'(out_data_o.cons_addr));
          check_field("src_reg", 32'(want.src_reg),
                      32'(out_data_o.src_reg));
          check_field("producer_valid", 32'(want.producer_valid),
                      32'(out_data_o.producer_valid));
          check_field("prod_addr", 32'(want.prod_addr),
                      32'(out_data_o.prod_addr));
          check_field("previous_valid", 32'(want.previous_valid),
                      32'(out_data_o.previous_valid));
          check_field("previous_address", 32'(want.previous_address),
                      32'(out_data_o.previous_address));
          check_field("last", 32'(want.last), 32'(out_data_o.last));
        end
      end
      quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned gen_len;
    int unsigned rand_cmds;
    int unsigned prog_idx;
    int unsigned n_loads;
    logic [BlockW-1:0] blk;

    // Directed program: every dependency kind, duplicates, block tag 3,
    // registers 0 and 31, bad addresses on both sides and the unused mode.
    queue_cmd(other_cmd(MODE_REPORT, 6'd0));
    queue_cmd(load_cmd(BLK_SETUP, 1, 0,  0, 31, 0, 31, 0, 31));
    queue_cmd(load_cmd(BLK_SETUP, 1, 31, 1, 0,  0, 0,  0, 0));
    queue_cmd(load_cmd(BLK_BODY,  1, 0,  1, 0,  1, 31, 1, 0));
    queue_cmd(load_cmd(BLK_BODY,  1, 5,  1, 5,  1, 0,  1, 31));
    queue_cmd(load_cmd(BLK_AFTER, 1, 7,  1, 0,  1, 31, 1, 9));
    queue_cmd(load_cmd(BLK_OTHER, 1, 9,  1, 7,  1, 9,  0, 9));
    queue_cmd(load_cmd(BLK_OTHER, 0, 9,  1, 9,  0, 0,  0, 0));
    queue_cmd(load_cmd(BLK_SETUP, 0, 31, 1, 31, 1, 20, 0, 0));
    queue_cmd(load_cmd(BLK_AFTER, 0, 5,  1, 5,  1, 5,  1, 5));
    for (int a = 0; a <= 9; a++) begin
      queue_cmd(other_cmd(MODE_REPORT, AddrW'(a)));
    end
    queue_cmd(other_cmd(MODE_REPORT, 6'd63));
    queue_cmd(other_cmd(MODE_SPARE, 6'd2));
    queue_cmd(other_cmd(MODE_CLEAR, 6'd0));
    queue_cmd(other_cmd(MODE_REPORT, 6'd0));

    // Random programs: setup, loop body and after-loop instructions in order
    // with a few stray tags, reports spread through the loading, and one
    // program that runs past the depth.
    gen_len   = 0;
    rand_cmds = 0;
    prog_idx  = 0;
    while (rand_cmds < 175) begin
      queue_cmd(other_cmd(MODE_CLEAR, AddrW'($urandom_range(0, 63))));
      gen_len = 0;
      rand_cmds++;
      n_loads = (prog_idx == 1) ? PROGRAM_DEPTH + 2 : $urandom_range(3, 14);
      for (int unsigned i = 0; i < n_loads; i++) begin
        if ($urandom_range(0, 7) == 0) blk = BlockW'($urandom_range(0, 3));
        else if (i < n_loads / 3) blk = BLK_SETUP;
        else if (i < 2 * n_loads / 3) blk = BLK_BODY;
        else blk = BLK_AFTER;
        queue_cmd(rand_instr(blk));
        if (gen_len < PROGRAM_DEPTH) gen_len++;
        rand_cmds++;
        if ($urandom_range(0, 2) == 0 || i + 1 == n_loads) begin
          for (int unsigned k = $urandom_range(1, 4); k > 0; k--) begin
            if ($urandom_range(0, 7) == 0 && gen_len < PROGRAM_DEPTH) begin
              queue_cmd(other_cmd(MODE_REPORT, AddrW'($urandom_range(gen_len, 63))));
            end else begin
              queue_cmd(other_cmd(MODE_REPORT, AddrW'($urandom_range(0, gen_len - 1))));
            end
            rand_cmds++;
          end
        end
        if ($urandom_range(0, 24) == 0) begin
          queue_cmd(other_cmd(MODE_SPARE, AddrW'($urandom_range(0, 63))));
        end
      end
      prog_idx++;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_cmd_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_deps_q.size() != 0) @(posedge clk_i);
    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
